// ----- hw/rtl/tgc_pkg.sv -----
// Shared types and constants for the token graph colouring node.
// Holds the item and result structs, op and kind codes, and the
// command and status structs between controller and datapath.
package tgc_pkg;

  localparam int MAX_NEIGHBOURS = 16;
  localparam int MAX_COLOUR     = MAX_NEIGHBOURS + 1;
  localparam int NUM_COLOURS    = MAX_NEIGHBOURS + 2;
  localparam int QIDX_W         = $clog2(MAX_NEIGHBOURS);

  // Input op codes.
  localparam logic [2:0] OP_START       = 3'd0;
  localparam logic [2:0] OP_NB_COLOURED = 3'd1;
  localparam logic [2:0] OP_COLOUR_REQ  = 3'd2;
  localparam logic [2:0] OP_TOKEN_REQ   = 3'd3;
  localparam logic [2:0] OP_COLOUR_REP  = 3'd4;
  localparam logic [2:0] OP_TOKEN_PASS  = 3'd5;
  localparam logic [2:0] OP_ROUND_END   = 3'd6;

  // Result kind codes.
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_COLOUR_REQ = 3'd1;
  localparam logic [2:0] KIND_TOKEN_REQ  = 3'd2;
  localparam logic [2:0] KIND_COLOUR_REP = 3'd3;
  localparam logic [2:0] KIND_TOKEN_PASS = 3'd4;
  localparam logic [2:0] KIND_COLOURED   = 3'd5;

  // Configuration register indexes.
  localparam logic REG_NEIGHBOUR_COUNT  = 1'b0;
  localparam logic REG_START_WITH_TOKEN = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] neighbour;
    logic [7:0] colour_in;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       to_all;
    logic [3:0] dest;
    logic [4:0] colour_out;
    logic       last;
    logic       finished;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_rd;
    logic scan_wr;
    logic scan_end;
    logic decide;
    logic load0;
    logic load1;
  } cmd_t;

  typedef struct packed {
    logic       op_round;
    logic       scan_more;
    logic [1:0] n_res;
    logic       out_free;
  } sts_t;

endpackage

// ----- hw/rtl/tgc_ctrl.sv -----
// Controller state machine of the token graph colouring node.
// Depends on tgc_pkg for the command and status structs.
module tgc_ctrl import tgc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_SCAN_RD = 3'd2;
  localparam logic [2:0] ST_SCAN_WR = 3'd3;
  localparam logic [2:0] ST_DECIDE  = 3'd4;
  localparam logic [2:0] ST_EMIT0   = 3'd5;
  localparam logic [2:0] ST_EMIT1   = 3'd6;
  localparam logic [2:0] ST_SPARE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.op_round ? ST_SCAN_RD : ST_EMIT0;
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_WR;
        end else begin
          cmd_o.scan_end = 1'b1;
          state_d        = ST_DECIDE;
        end
      end
      ST_SCAN_WR: begin
        cmd_o.scan_wr = 1'b1;
        state_d       = ST_SCAN_RD;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (sts_i.n_res == 2'd0) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.load0 = 1'b1;
          state_d     = (sts_i.n_res == 2'd1) ? ST_IDLE : ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (sts_i.out_free) begin
          cmd_o.load1 = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SPARE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/tgc_dp.sv -----
// Datapath of the token graph colouring node: configuration registers,
// node state, requester queue memory, colour pick and result register.
// Depends on tgc_pkg for item, result, command and status types.
module tgc_dp import tgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  item_t       in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata
);

  logic [4:0]             nc_q;
  logic                   swt_q;
  logic                   has_token_q, has_token_d;
  logic                   coloured_q, coloured_d;
  logic [4:0]             my_colour_q, my_colour_d;
  logic [4:0]             replies_q, replies_d;
  logic [NUM_COLOURS-1:0] used_q, used_d;
  logic [15:0]            coln_q, coln_d;
  logic [4:0]             colcnt_q, colcnt_d;
  logic [4:0]             head_q, head_d;
  logic [4:0]             tail_q, tail_d;
  logic [3:0]             pred_q, pred_d;
  logic                   handed_back_q, handed_back_d;
  logic                   blocked_q, blocked_d;
  logic [4:0]             scan_i_q, scan_i_d;
  logic [4:0]             scan_w_q, scan_w_d;
  logic [1:0]             nres_q, nres_d;
  logic                   out_valid_q, out_valid_d;

  item_t                  in_q, in_d;
  result_t                res0_q, res0_d, res1_q, res1_d;
  result_t                out_q, out_d;

  logic [3:0]             mem [MAX_NEIGHBOURS];
  logic [3:0]             rdata_q;
  logic                   mem_we;
  logic [QIDX_W-1:0]      mem_waddr;
  logic [3:0]             mem_wdata;
  logic                   rd_en;
  logic [QIDX_W-1:0]      rd_addr;

  logic [4:0]             cnt;
  logic                   ignore;
  logic                   cfg_we;
  logic                   col_now;
  logic                   hand;
  logic                   fin;
  result_t                tp;

  function automatic logic [4:0] pick_colour(input logic [NUM_COLOURS-1:0] used);
    logic [4:0] c;
    c = 5'(MAX_COLOUR);
    for (int k = MAX_COLOUR; k >= 1; k--) begin
      if (!used[k]) c = 5'(k);
    end
    return c;
  endfunction

  assign cnt    = (nc_q > 5'(MAX_NEIGHBOURS)) ? 5'(MAX_NEIGHBOURS) : nc_q;
  assign ignore = ((in_q.op >= OP_NB_COLOURED) && (in_q.op <= OP_TOKEN_PASS) &&
                   ({1'b0, in_q.neighbour} >= cnt)) || (in_q.op > OP_ROUND_END);
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_NEIGHBOUR_COUNT:  prdata = {27'd0, nc_q};
      REG_START_WITH_TOKEN: prdata = {31'd0, swt_q};
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    has_token_d   = has_token_q;
    coloured_d    = coloured_q;
    my_colour_d   = my_colour_q;
    replies_d     = replies_q;
    used_d        = used_q;
    coln_d        = coln_q;
    colcnt_d      = colcnt_q;
    head_d        = head_q;
    tail_d        = tail_q;
    pred_d        = pred_q;
    handed_back_d = handed_back_q;
    blocked_d     = blocked_q;
    scan_i_d      = scan_i_q;
    scan_w_d      = scan_w_q;
    nres_d        = nres_q;
    in_d          = in_q;
    res0_d        = res0_q;
    res1_d        = res1_q;
    mem_we        = 1'b0;
    mem_waddr     = tail_q[QIDX_W-1:0];
    mem_wdata     = in_q.neighbour;
    rd_en         = 1'b0;
    rd_addr       = head_q[QIDX_W-1:0];
    col_now       = 1'b0;
    hand          = 1'b0;
    fin           = 1'b0;
    tp            = '0;

    if (cmd_i.capture) in_d = in_item_i;

    if (cmd_i.exec) begin
      nres_d   = 2'd0;
      res0_d   = '0;
      scan_i_d = head_q;
      scan_w_d = head_q;
      if (!ignore) begin
        unique case (in_q.op)
          OP_START: begin
            has_token_d   = swt_q;
            handed_back_d = swt_q;
            res0_d.kind   = swt_q ? KIND_COLOUR_REQ : KIND_TOKEN_REQ;
            res0_d.to_all = 1'b1;
            nres_d        = 2'd1;
          end
          OP_NB_COLOURED: begin
            if (!coln_q[in_q.neighbour]) begin
              coln_d[in_q.neighbour] = 1'b1;
              colcnt_d               = colcnt_q + 5'd1;
            end
          end
          OP_COLOUR_REQ: begin
            res0_d.kind = KIND_COLOUR_REP;
            res0_d.dest = in_q.neighbour;
            nres_d      = 2'd1;
          end
          OP_TOKEN_REQ: begin
            if (tail_q < 5'(MAX_NEIGHBOURS)) begin
              mem_we = 1'b1;
              tail_d = tail_q + 5'd1;
            end
          end
          OP_COLOUR_REP: begin
            if (!coloured_q) begin
              if (in_q.colour_in <= 8'(MAX_COLOUR)) used_d[in_q.colour_in[4:0]] = 1'b1;
              if (replies_q != 5'd31) replies_d = replies_q + 5'd1;
            end
          end
          OP_TOKEN_PASS: begin
            has_token_d = 1'b1;
            if (!coloured_q) begin
              pred_d        = in_q.neighbour;
              res0_d.kind   = KIND_COLOUR_REQ;
              res0_d.to_all = 1'b1;
              nres_d        = 2'd1;
            end else begin
              blocked_d = 1'b1;
            end
          end
          default: begin
            nres_d = 2'd0;
          end
        endcase
      end
      fin = (colcnt_d >= cnt) && coloured_q && handed_back_d;
      res0_d.colour_out = my_colour_q;
      res0_d.finished   = fin;
    end

    // Compaction keeps uncoloured requesters in order, writing behind the read pointer.
    if (cmd_i.scan_rd) begin
      rd_en   = 1'b1;
      rd_addr = scan_i_q[QIDX_W-1:0];
    end
    if (cmd_i.scan_wr) begin
      if (!coln_q[rdata_q]) begin
        mem_we    = 1'b1;
        mem_waddr = scan_w_q[QIDX_W-1:0];
        mem_wdata = rdata_q;
        scan_w_d  = scan_w_q + 5'd1;
      end
      scan_i_d = scan_i_q + 5'd1;
    end
    if (cmd_i.scan_end) begin
      tail_d = scan_w_q;
      rd_en  = 1'b1;
    end

    if (cmd_i.decide) begin
      col_now = (replies_q >= cnt) && !coloured_q && has_token_q;
      res0_d  = '0;
      res1_d  = '0;
      nres_d  = 2'd0;
      if (col_now) begin
        my_colour_d   = pick_colour(used_q);
        coloured_d    = 1'b1;
        res0_d.kind   = KIND_COLOURED;
        res0_d.to_all = 1'b1;
        nres_d        = 2'd1;
      end
      hand    = has_token_q && coloured_d && !blocked_q;
      tp.kind = KIND_TOKEN_PASS;
      if (hand) begin
        if (head_q < tail_q) begin
          tp.dest     = rdata_q;
          head_d      = head_q + 5'd1;
          has_token_d = 1'b0;
          nres_d      = col_now ? 2'd2 : 2'd1;
        end else if (!swt_q) begin
          tp.dest       = pred_q;
          has_token_d   = 1'b0;
          handed_back_d = 1'b1;
          nres_d        = col_now ? 2'd2 : 2'd1;
        end
      end
      if (nres_d == 2'd2) begin
        res1_d = tp;
      end else if (nres_d == 2'd1 && !col_now) begin
        res0_d = tp;
      end
      blocked_d = 1'b0;
      fin = (colcnt_q >= cnt) && coloured_d && handed_back_d;
      res0_d.colour_out = my_colour_d;
      res0_d.finished   = fin;
      res1_d.colour_out = my_colour_d;
      res1_d.finished   = fin;
    end
  end

  // Result register: one slot between the emit sequence and the consumer.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i.load0) begin
      out_d       = res0_q;
      out_d.last  = (nres_q == 2'd1);
      out_valid_d = 1'b1;
    end else if (cmd_i.load1) begin
      out_d       = res1_q;
      out_d.last  = 1'b1;
      out_valid_d = 1'b1;
    end
  end

  assign sts_o.op_round  = (in_q.op == OP_ROUND_END);
  assign sts_o.scan_more = (scan_i_q < tail_q);
  assign sts_o.n_res     = nres_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    res0_q <= res0_d;
    res1_q <= res1_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q          <= '0;
      swt_q         <= 1'b0;
      has_token_q   <= 1'b0;
      coloured_q    <= 1'b0;
      my_colour_q   <= '0;
      replies_q     <= '0;
      used_q        <= '0;
      coln_q        <= '0;
      colcnt_q      <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      pred_q        <= '0;
      handed_back_q <= 1'b0;
      blocked_q     <= 1'b0;
      scan_i_q      <= '0;
      scan_w_q      <= '0;
      nres_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[2])
          REG_NEIGHBOUR_COUNT:  nc_q  <= pwdata[4:0];
          REG_START_WITH_TOKEN: swt_q <= pwdata[0];
          default:              nc_q  <= nc_q;
        endcase
      end
      has_token_q   <= has_token_d;
      coloured_q    <= coloured_d;
      my_colour_q   <= my_colour_d;
      replies_q     <= replies_d;
      used_q        <= used_d;
      coln_q        <= coln_d;
      colcnt_q      <= colcnt_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      pred_q        <= pred_d;
      handed_back_q <= handed_back_d;
      blocked_q     <= blocked_d;
      scan_i_q      <= scan_i_d;
      scan_w_q      <= scan_w_d;
      nres_q        <= nres_d;
      out_valid_q   <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/token_graph_colouring_node.sv -----
// Sequence: an accepted item is captured, executed, then its results are loaded into the
// result register as it frees; a round end compacts the queue and decides before that.
// Throughput: no new item is accepted until the previous one has emitted all its
// results; the requester queue compaction, reading then writing each entry, lengthens round ends.
// Reset: control state and node state clear at once; the queue memory is not
// cleared and holds nothing until requesters are written.
module token_graph_colouring_node import tgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  item_t       in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  tgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  tgc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule

// ----- hw/rtl/tgc_checker.sv -----
// Port-level checks for the token graph colouring node, bound to the top level.
// Depends on tgc_pkg for the result struct and kind codes.
module tgc_checker import tgc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input result_t out_item_o,
  input logic    pready
);

  // A result waiting on a stalled consumer stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Broadcast results carry no destination.
  a_bcast_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.to_all |-> out_item_o.dest == 4'd0)
    else $error("broadcast result with nonzero dest");

  // Every delivered result is a real message kind.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.kind != KIND_NONE && out_item_o.kind <= KIND_COLOURED)
    else $error("result with invalid kind");

  // A finished node has a colour, and a colour broadcast carries one.
  a_fin_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.finished || out_item_o.kind == KIND_COLOURED)
      |-> out_item_o.colour_out != 5'd0)
    else $error("finished or coloured result without a colour");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind token_graph_colouring_node tgc_checker u_tgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);
